// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/asc_pkg.sv =====
// types and constants of the audio sync sample corrector
package asc_pkg;

  localparam int COUNT_W    = 16;
  localparam int WANTED_W   = 17;
  localparam int CLOCK_W    = 32;
  localparam int COEF_W     = 16;
  localparam int LIMIT_W    = 31;
  localparam int RATE_W     = 19;
  localparam int PCT_W      = 7;
  localparam int FRAMES_W   = 8;
  localparam int ACC_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // shared multiplier: signed 25 x signed 20, wide operands go in two 24-bit halves
  localparam int CHUNK_W    = 24;
  localparam int MUL_A_W    = CHUNK_W + 1;
  localparam int MUL_B_W    = RATE_W + 1;
  localparam int MUL_PROD_W = MUL_A_W + MUL_B_W;
  localparam int PROD_W     = 66;
  localparam int COEF_FRAC  = 16;

  // bounds: count * (100 -/+ pct) then / 100 via reciprocal
  localparam int BND_W      = 24;
  localparam int RECIP_W    = 26;
  localparam int RECIP_SH   = 32;
  localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;
  localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ENABLE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_COEF           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOSYNC_LIMIT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CORRECTION_PERCENT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_FRAMES      = 3'd6;

  // register reset values
  localparam logic                RST_SYNC_ENABLE        = 1'b1;
  localparam logic [COEF_W-1:0]   RST_AVG_COEF           = 16'd52057;
  localparam logic [LIMIT_W-1:0]  RST_DIFF_THRESHOLD     = 31'd1398;
  localparam logic [RATE_W-1:0]   RST_SOURCE_RATE        = 19'd48000;
  localparam logic [LIMIT_W-1:0]  RST_NOSYNC_LIMIT       = 31'd655360;
  localparam logic [PCT_W-1:0]    RST_CORRECTION_PERCENT = 7'd10;
  localparam logic [FRAMES_W-1:0] RST_WARMUP_FRAMES      = 8'd20;

  typedef struct packed {
    logic                sync_enable;
    logic [COEF_W-1:0]   avg_coef;
    logic [LIMIT_W-1:0]  diff_threshold;
    logic [RATE_W-1:0]   source_rate;
    logic [LIMIT_W-1:0]  nosync_limit;
    logic [PCT_W-1:0]    correction_percent;
    logic [FRAMES_W-1:0] warmup_frames;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_M1A,
    ST_M1B,
    ST_UPD,
    ST_M2A,
    ST_M2B,
    ST_CMP,
    ST_M3A,
    ST_M3B,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_ACC_COEF,
    MUL_AVG,
    MUL_RATE
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    logic     mul_hi;
    mul_sel_t mul_sel;
    logic     bnd_en;
    logic     upd_acc;
    logic     clr_state;
    logic     res_pass;
    logic     res_corr;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic usable;
    logic warm;
    logic trigger;
  } sts_t;

endpackage

// ===== sv/asc_in_if.sv =====
// input channel: one decoded frame word
interface asc_in_if;
  logic                                valid;
  logic                                ready;
  logic [asc_pkg::COUNT_W-1:0]         sample_count;
  logic signed [asc_pkg::CLOCK_W-1:0]  clock_diff;
  logic                                diff_valid;

  modport source (output valid, sample_count, clock_diff, diff_valid, input ready);
  modport sink   (input valid, sample_count, clock_diff, diff_valid, output ready);
endinterface

// ===== sv/asc_out_if.sv =====
// result channel: corrected sample count word
interface asc_out_if;
  logic                         valid;
  logic                         ready;
  logic [asc_pkg::WANTED_W-1:0] wanted_samples;
  logic                         corrected;

  modport source (output valid, wanted_samples, corrected, input ready);
  modport sink   (input valid, wanted_samples, corrected, output ready);
endinterface

// ===== sv/asc_dp.sv =====
// datapath: accumulator, shared multiplier, bounds and clipping
module asc_dp #(
  parameter int DIFF_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  asc_pkg::cfg_t                      cfg,
  input  logic [asc_pkg::COUNT_W-1:0]        in_sample_count,
  input  logic signed [asc_pkg::CLOCK_W-1:0] in_clock_diff,
  input  logic                               in_diff_valid,
  input  asc_pkg::cmd_t                      cmd,
  output asc_pkg::sts_t                      sts,
  output logic [asc_pkg::WANTED_W-1:0]       res_wanted,
  output logic                               res_corrected
);

  localparam int PW = asc_pkg::PROD_W;
  localparam int AW = asc_pkg::ACC_W;
  localparam int CW = asc_pkg::CHUNK_W;
  localparam int WW = 53;

  logic [asc_pkg::COUNT_W-1:0]        count_r;
  logic signed [asc_pkg::CLOCK_W-1:0] diff_r;
  logic                               dvalid_r;
  logic [asc_pkg::CLOCK_W-1:0]        mag_r;
  logic signed [AW-1:0]               acc_r;
  logic [asc_pkg::FRAMES_W-1:0]       frames_r;
  logic signed [PW-1:0]               p_r;
  logic signed [PW-1:0]               p_nxt;
  logic [asc_pkg::BND_W-1:0]          blo_prod_r;
  logic [asc_pkg::BND_W-1:0]          bhi_prod_r;
  logic [asc_pkg::WANTED_W-1:0]       lo_r;
  logic [asc_pkg::WANTED_W-1:0]       hi_r;
  logic [asc_pkg::WANTED_W-1:0]       res_wanted_r;
  logic                               res_corr_r;

  logic [asc_pkg::CLOCK_W-1:0]        in_mag;
  logic [AW-1:0]                      mul_src;
  logic [asc_pkg::MUL_B_W-1:0]        mul_f;
  logic [asc_pkg::COEF_W:0]           f_avg;
  logic signed [asc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [asc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [asc_pkg::MUL_PROD_W-1:0] mul_prod;
  logic signed [PW-1:0]               prod_ext;

  logic signed [PW-1:0]               p_shr;
  logic signed [PW-1:0]               rnd;
  logic signed [PW-1:0]               q;
  logic signed [PW-1:0]               diff_ext;
  logic signed [PW-1:0]               acc_sum;
  logic                               acc_ovf;
  logic signed [AW-1:0]               acc_new;
  logic [PW-1:0]                      avg_mag;

  logic [asc_pkg::PCT_W-1:0]          pct;
  logic [asc_pkg::FRAMES_W-1:0]       pct_minus;
  logic [asc_pkg::FRAMES_W-1:0]       pct_plus;
  logic [asc_pkg::BND_W-1:0]          cnt_bnd;
  logic [asc_pkg::BND_W-1:0]          pct_minus_bnd;
  logic [asc_pkg::BND_W-1:0]          pct_plus_bnd;
  logic [49:0]                        qlo_full;
  logic [49:0]                        qhi_full;

  logic [PW-1:0]                      dmag_full;
  logic signed [WW-1:0]               cnt_w;
  logic signed [WW-1:0]               dmag_w;
  logic signed [WW-1:0]               w_raw;
  logic signed [WW-1:0]               w_clip;

  // magnitude of the incoming difference, full range of the signed word
  assign in_mag = in_clock_diff[asc_pkg::CLOCK_W-1] ? (~in_clock_diff + 32'd1) : in_clock_diff;

  // shared multiplier operand selection
  assign f_avg = 17'h10000 - {1'b0, cfg.avg_coef};

  always_comb begin
    unique case (cmd.mul_sel)
      asc_pkg::MUL_ACC_COEF: begin
        mul_src = acc_r;
        mul_f   = {{(asc_pkg::MUL_B_W-asc_pkg::COEF_W){1'b0}}, cfg.avg_coef};
      end
      asc_pkg::MUL_AVG: begin
        mul_src = acc_r;
        mul_f   = {{(asc_pkg::MUL_B_W-asc_pkg::COEF_W-1){1'b0}}, f_avg};
      end
      asc_pkg::MUL_RATE: begin
        mul_src = {{(AW-asc_pkg::CLOCK_W){1'b0}}, mag_r};
        mul_f   = {1'b0, cfg.source_rate};
      end
      default: begin
        mul_src = '0;
        mul_f   = '0;
      end
    endcase
  end

  assign mul_a    = cmd.mul_hi ? $signed({mul_src[AW-1], mul_src[AW-1:CW]})
                               : $signed({1'b0, mul_src[CW-1:0]});
  assign mul_b    = $signed(mul_f);
  assign mul_prod = mul_a * mul_b;
  assign prod_ext = $signed({{(PW-asc_pkg::MUL_PROD_W){mul_prod[asc_pkg::MUL_PROD_W-1]}},
                             mul_prod});
  assign p_nxt    = cmd.mul_hi ? (p_r + (prod_ext <<< CW)) : prod_ext;

  // product / 2^16 rounded half up
  assign p_shr = p_r >>> asc_pkg::COEF_FRAC;
  assign rnd   = $signed({{(PW-1){1'b0}}, p_r[asc_pkg::COEF_FRAC-1]});
  assign q     = p_shr + rnd;

  // accumulator update with 48-bit saturation
  assign diff_ext = $signed({{(PW-asc_pkg::CLOCK_W){diff_r[asc_pkg::CLOCK_W-1]}}, diff_r});
  assign acc_sum  = q + diff_ext;
  assign acc_ovf  = !((&acc_sum[PW-1:AW-1]) || !(|acc_sum[PW-1:AW-1]));
  assign acc_new  = !acc_ovf ? acc_sum[AW-1:0]
                  : (acc_sum[PW-1] ? $signed({1'b1, {(AW-1){1'b0}}})
                                   : $signed({1'b0, {(AW-1){1'b1}}}));

  assign avg_mag = q[PW-1] ? PW'(-q) : PW'(q);

  // clip bounds
  assign pct       = (cfg.correction_percent > asc_pkg::PCT_MAX) ? asc_pkg::PCT_MAX
                                                                 : cfg.correction_percent;
  assign pct_minus = {1'b0, asc_pkg::PCT_MAX} - {1'b0, pct};
  assign pct_plus  = {1'b0, asc_pkg::PCT_MAX} + {1'b0, pct};
  assign cnt_bnd       = {{(asc_pkg::BND_W-asc_pkg::COUNT_W){1'b0}}, count_r};
  assign pct_minus_bnd = {{(asc_pkg::BND_W-asc_pkg::FRAMES_W){1'b0}}, pct_minus};
  assign pct_plus_bnd  = {{(asc_pkg::BND_W-asc_pkg::FRAMES_W){1'b0}}, pct_plus};
  assign qlo_full  = 50'(blo_prod_r) * 50'(asc_pkg::RECIP_100);
  assign qhi_full  = 50'(bhi_prod_r) * 50'(asc_pkg::RECIP_100);

  // corrected count and clipping
  assign dmag_full = p_r >> DIFF_FRAC_BITS;
  assign cnt_w     = $signed({{(WW-asc_pkg::COUNT_W){1'b0}}, count_r});
  assign dmag_w    = $signed({1'b0, dmag_full[WW-2:0]});
  assign w_raw     = diff_r[asc_pkg::CLOCK_W-1] ? (cnt_w - dmag_w) : (cnt_w + dmag_w);

  always_comb begin
    w_clip = w_raw;
    if (w_raw < $signed({{(WW-asc_pkg::WANTED_W){1'b0}}, lo_r})) begin
      w_clip = $signed({{(WW-asc_pkg::WANTED_W){1'b0}}, lo_r});
    end else if (w_raw > $signed({{(WW-asc_pkg::WANTED_W){1'b0}}, hi_r})) begin
      w_clip = $signed({{(WW-asc_pkg::WANTED_W){1'b0}}, hi_r});
    end
  end

  // status
  assign sts.enable  = cfg.sync_enable;
  assign sts.usable  = dvalid_r && (mag_r < {1'b0, cfg.nosync_limit});
  assign sts.warm    = frames_r < cfg.warmup_frames;
  assign sts.trigger = avg_mag >= {{(PW-asc_pkg::LIMIT_W){1'b0}}, cfg.diff_threshold};

  // history state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      frames_r <= '0;
    end else if (cmd.clr_state) begin
      acc_r    <= '0;
      frames_r <= '0;
    end else if (cmd.upd_acc) begin
      acc_r <= acc_new;
      if (sts.warm) begin
        frames_r <= frames_r + 8'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      count_r  <= in_sample_count;
      diff_r   <= in_clock_diff;
      dvalid_r <= in_diff_valid;
      mag_r    <= in_mag;
    end
    if (cmd.mul_en) begin
      p_r <= p_nxt;
    end
    if (cmd.bnd_en && !cmd.mul_hi) begin
      blo_prod_r <= cnt_bnd * pct_minus_bnd;
      bhi_prod_r <= cnt_bnd * pct_plus_bnd;
    end
    if (cmd.bnd_en && cmd.mul_hi) begin
      lo_r <= qlo_full[asc_pkg::RECIP_SH +: asc_pkg::WANTED_W];
      hi_r <= qhi_full[asc_pkg::RECIP_SH +: asc_pkg::WANTED_W];
    end
    if (cmd.res_pass) begin
      res_wanted_r <= {1'b0, count_r};
      res_corr_r   <= 1'b0;
    end else if (cmd.res_corr) begin
      res_wanted_r <= w_clip[asc_pkg::WANTED_W-1:0];
      res_corr_r   <= 1'b1;
    end
  end

  assign res_wanted    = res_wanted_r;
  assign res_corrected = res_corr_r;

endmodule

// ===== sv/asc_ctrl.sv =====
// controller: sequences one frame word through the datapath
module asc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_busy,
  input  asc_pkg::sts_t sts,
  output asc_pkg::cmd_t cmd
);

  asc_pkg::state_t state_r;
  asc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = asc_pkg::MUL_ACC_COEF;
    in_ready    = 1'b0;
    unique case (state_r)
      asc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = asc_pkg::ST_CHECK;
        end
      end
      asc_pkg::ST_CHECK: begin
        priority if (!sts.enable) begin
          cmd.res_pass = 1'b1;
          state_nxt    = asc_pkg::ST_EMIT;
        end else if (!sts.usable) begin
          cmd.clr_state = 1'b1;
          cmd.res_pass  = 1'b1;
          state_nxt     = asc_pkg::ST_EMIT;
        end else begin
          state_nxt = asc_pkg::ST_M1A;
        end
      end
      asc_pkg::ST_M1A: begin
        cmd.mul_en = 1'b1;
        state_nxt  = asc_pkg::ST_M1B;
      end
      asc_pkg::ST_M1B: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi = 1'b1;
        state_nxt  = asc_pkg::ST_UPD;
      end
      asc_pkg::ST_UPD: begin
        cmd.upd_acc = 1'b1;
        if (sts.warm) begin
          cmd.res_pass = 1'b1;
          state_nxt    = asc_pkg::ST_EMIT;
        end else begin
          state_nxt = asc_pkg::ST_M2A;
        end
      end
      asc_pkg::ST_M2A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = asc_pkg::MUL_AVG;
        state_nxt   = asc_pkg::ST_M2B;
      end
      asc_pkg::ST_M2B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_hi  = 1'b1;
        cmd.mul_sel = asc_pkg::MUL_AVG;
        state_nxt   = asc_pkg::ST_CMP;
      end
      asc_pkg::ST_CMP: begin
        if (sts.trigger) begin
          state_nxt = asc_pkg::ST_M3A;
        end else begin
          cmd.res_pass = 1'b1;
          state_nxt    = asc_pkg::ST_EMIT;
        end
      end
      asc_pkg::ST_M3A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = asc_pkg::MUL_RATE;
        cmd.bnd_en  = 1'b1;
        state_nxt   = asc_pkg::ST_M3B;
      end
      asc_pkg::ST_M3B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_hi  = 1'b1;
        cmd.mul_sel = asc_pkg::MUL_RATE;
        cmd.bnd_en  = 1'b1;
        state_nxt   = asc_pkg::ST_FIN;
      end
      asc_pkg::ST_FIN: begin
        cmd.res_corr = 1'b1;
        state_nxt    = asc_pkg::ST_EMIT;
      end
      asc_pkg::ST_EMIT: begin
        if (!out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = asc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = asc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/audio_sync_sample_corrector_unit.sv =====
// top level of the audio sync sample corrector
// Takes one decoded frame word (sample count, audio-minus-master clock
// difference in signed fixed point, and a flag that the difference is a
// number) and returns one word with the sample count to produce and a flag
// that the count was recomputed from the difference. A usable difference
// (flagged valid and smaller in magnitude than nosync_limit) feeds a 48-bit
// exponentially weighted accumulator; after warmup_frames usable frames the
// scaled average is compared with diff_threshold and, once reached, the count
// becomes count plus diff times source_rate, clipped to correction_percent of
// the count. With sync enabled, an unusable difference clears the history.
// After the check, sync off or an unusable difference passes the count; else
// the accumulator is updated and, after warm-up, the average is compared; at
// the threshold the rate product and bounds give the clipped count, else the
// count passes. The single shared 25x20 multiplier builds each wide product
// (accumulator times coefficient, accumulator times one minus coefficient,
// difference times rate) from two 24-bit halves on consecutive cycles. The
// result sits in an output register, so the next word is accepted while the
// previous result still waits to be taken. The user must write registers
// through cfg_we/cfg_index/cfg_data only while the block is idle (not enforced).
`include "assert_macros.svh"

module audio_sync_sample_corrector_unit #(
  parameter int DIFF_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  asc_in_if.sink                            in_ch,
  asc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [asc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  asc_pkg::cfg_t cfg_r;
  asc_pkg::cmd_t cmd;
  asc_pkg::sts_t sts;

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [asc_pkg::WANTED_W-1:0]  out_wanted_r;
  logic                          out_corr_r;
  logic [asc_pkg::WANTED_W-1:0]  res_wanted;
  logic                          res_corrected;
  logic                          out_busy;
  logic                          in_ready;

  // register file, written by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_enable        <= asc_pkg::RST_SYNC_ENABLE;
      cfg_r.avg_coef           <= asc_pkg::RST_AVG_COEF;
      cfg_r.diff_threshold     <= asc_pkg::RST_DIFF_THRESHOLD;
      cfg_r.source_rate        <= asc_pkg::RST_SOURCE_RATE;
      cfg_r.nosync_limit       <= asc_pkg::RST_NOSYNC_LIMIT;
      cfg_r.correction_percent <= asc_pkg::RST_CORRECTION_PERCENT;
      cfg_r.warmup_frames      <= asc_pkg::RST_WARMUP_FRAMES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asc_pkg::CFG_SYNC_ENABLE:        cfg_r.sync_enable <= cfg_data[0];
        asc_pkg::CFG_AVG_COEF:           cfg_r.avg_coef <= cfg_data[asc_pkg::COEF_W-1:0];
        asc_pkg::CFG_DIFF_THRESHOLD:     cfg_r.diff_threshold <= cfg_data[asc_pkg::LIMIT_W-1:0];
        asc_pkg::CFG_SOURCE_RATE:        cfg_r.source_rate <= cfg_data[asc_pkg::RATE_W-1:0];
        asc_pkg::CFG_NOSYNC_LIMIT:       cfg_r.nosync_limit <= cfg_data[asc_pkg::LIMIT_W-1:0];
        asc_pkg::CFG_CORRECTION_PERCENT: begin
          cfg_r.correction_percent <= cfg_data[asc_pkg::PCT_W-1:0];
        end
        asc_pkg::CFG_WARMUP_FRAMES:      cfg_r.warmup_frames <= cfg_data[asc_pkg::FRAMES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  asc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_busy (out_busy),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and history
  asc_dp #(
    .DIFF_FRAC_BITS (DIFF_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_sample_count (in_ch.sample_count),
    .in_clock_diff   (in_ch.clock_diff),
    .in_diff_valid   (in_ch.diff_valid),
    .cmd             (cmd),
    .sts             (sts),
    .res_wanted      (res_wanted),
    .res_corrected   (res_corrected)
  );

  assign in_ch.ready = in_ready;

  // output word register, decouples the sequencer from the result sink
  assign out_busy = out_valid_r && !out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_wanted_r <= res_wanted;
      out_corr_r   <= res_corrected;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.wanted_samples = out_wanted_r;
  assign out_ch.corrected      = out_corr_r;

  // a pending output word is never overwritten
  `ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.emit, !out_valid_r || out_ch.ready)
  // an accepted word keeps the input closed through the check state and the state after it
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_NEXT(a_busy_two, clk, rst_n, $past(in_ch.valid && in_ch.ready), !in_ch.ready)
  // every emitted word leaves the output register full
  `ASSERT_NEXT(a_emit_fills, clk, rst_n, cmd.emit, out_valid_r)

endmodule
